// ===== rtl/sbda_pkg.sv =====
package sbda_pkg;

    // Width of the two's-complement input word.
    localparam int VALUE_WIDTH = 32;

    // Guard bits so that nine times a power of ten still fits.
    localparam int EXT_W  = 4;
    localparam int MULT_W = VALUE_WIDTH + EXT_W;

    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam int         RADIX      = 10;
    localparam int         DIGIT_W    = 4;

    // mult * RADIX**expn at the guarded width
    function automatic logic [MULT_W-1:0] mult_pow10(input int unsigned mult,
                                                     input int unsigned expn);
        logic [MULT_W-1:0] acc;
        acc = MULT_W'(mult);
        for (int unsigned i = 0; i < expn; i++)
        begin
            acc = acc * MULT_W'(RADIX);
        end
        return acc;
    endfunction

    // Digits in the largest magnitude, 2**(VALUE_WIDTH-1).
    function automatic int max_digit_count();
        logic [MULT_W-1:0] lim;
        logic [MULT_W-1:0] p;
        int                n;
        lim = MULT_W'(1) << (VALUE_WIDTH - 1);
        p   = MULT_W'(RADIX);
        n   = 1;
        for (int i = 0; i < 2 * VALUE_WIDTH; i++)
        begin
            if (p <= lim)
            begin
                n = n + 1;
                p = p * MULT_W'(RADIX);
            end
        end
        return n;
    endfunction

    localparam int MAX_DIGITS = max_digit_count();
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    // One classified number waiting for the digit sequencer.
    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
        logic [IDX_W-1:0]       top_idx;   // position of the leading digit
    } bd_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SIGN,
        BK_DIGIT
    } bk_state_t;

endpackage

// ===== rtl/sbda_if.sv =====
interface sbda_value_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sbda_pkg::VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sbda_char_if;
    logic       valid;
    logic       ready;
    logic [5:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ===== rtl/sbda_front.sv =====
module sbda_front (
    input  logic                 clk,
    input  logic                 rst_n,
    sbda_value_if.sink           number,
    output logic                 push_valid,
    input  logic                 push_ready,
    output sbda_pkg::bd_item_t   push_item
);

    logic                             fr_valid_reg;
    logic                             fr_valid_next;
    logic                             fr_neg_reg;
    logic [sbda_pkg::VALUE_WIDTH-1:0] fr_mag_reg;
    logic [sbda_pkg::VALUE_WIDTH-1:0] mag_in;
    logic                             accept;
    logic                             push;
    logic [sbda_pkg::MAX_DIGITS-1:0]  hit;
    logic [sbda_pkg::IDX_W-1:0]       top_idx;

    assign number.ready = !fr_valid_reg || push_ready;
    assign accept       = number.valid && number.ready;
    assign push         = fr_valid_reg && push_ready;

    // Unsigned magnitude; the most negative value maps onto itself, which is correct.
    assign mag_in = number.value[sbda_pkg::VALUE_WIDTH-1] ?
                    (~number.value + sbda_pkg::VALUE_WIDTH'(1)) : number.value;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_neg_reg <= number.value[sbda_pkg::VALUE_WIDTH-1];
            fr_mag_reg <= mag_in;
        end
    end

    // Decade compares against constants give the digit count.
    assign hit[0] = 1'b1;
    for (genvar k = 1; k < sbda_pkg::MAX_DIGITS; k++)
    begin : g_dec
        assign hit[k] = {{sbda_pkg::EXT_W{1'b0}}, fr_mag_reg} >=
                        sbda_pkg::mult_pow10(1, k);
    end

    always_comb
    begin
        top_idx = '0;
        for (int k = 0; k < sbda_pkg::MAX_DIGITS; k++)
        begin
            if (hit[k])
            begin
                top_idx = sbda_pkg::IDX_W'(k);
            end
        end
    end

    assign push_valid        = fr_valid_reg;
    assign push_item.neg     = fr_neg_reg;
    assign push_item.mag     = fr_mag_reg;
    assign push_item.top_idx = top_idx;

endmodule

// ===== rtl/sbda_queue.sv =====
module sbda_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  sbda_pkg::bd_item_t   push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output sbda_pkg::bd_item_t   pop_item
);

    sbda_pkg::bd_item_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/sbda_back.sv =====
module sbda_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  sbda_pkg::bd_item_t   pop_item,
    sbda_char_if.source          text
);

    sbda_pkg::bk_state_t              state_reg;
    sbda_pkg::bk_state_t              state_next;
    logic [sbda_pkg::VALUE_WIDTH-1:0] rem_reg;
    logic [sbda_pkg::VALUE_WIDTH-1:0] rem_next;
    logic [sbda_pkg::IDX_W-1:0]       idx_reg;
    logic [sbda_pkg::IDX_W-1:0]       idx_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [5:0]                       out_char_reg;
    logic [5:0]                       out_char_next;
    logic                             out_last_reg;
    logic                             out_last_next;
    logic                             adv;
    logic                             emit;
    logic [8:0]                       ge;
    logic [sbda_pkg::DIGIT_W-1:0]     digit;
    logic [sbda_pkg::MULT_W-1:0]      sub;

    // d * 10**k for d = 1..9, one row per digit position
    logic [sbda_pkg::MULT_W-1:0] step_tbl [sbda_pkg::MAX_DIGITS][9];

    for (genvar k = 0; k < sbda_pkg::MAX_DIGITS; k++)
    begin : g_pos
        for (genvar d = 0; d < 9; d++)
        begin : g_mul
            assign step_tbl[k][d] = sbda_pkg::mult_pow10(d + 1, k);
        end
    end

    assign adv = !out_valid_reg || text.ready;

    // Digit at the current position: how many multiples fit.
    for (genvar d = 0; d < 9; d++)
    begin : g_cmp
        assign ge[d] = {{sbda_pkg::EXT_W{1'b0}}, rem_reg} >= step_tbl[idx_reg][d];
    end

    always_comb
    begin
        digit = '0;
        for (int d = 0; d < 9; d++)
        begin
            digit = digit + sbda_pkg::DIGIT_W'(ge[d]);
        end
        sub = (digit == '0) ? '0 : step_tbl[idx_reg][digit - sbda_pkg::DIGIT_W'(1)];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbda_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = pop_item.neg ? sbda_pkg::BK_SIGN : sbda_pkg::BK_DIGIT;
                end
            end
            sbda_pkg::BK_SIGN:
            begin
                if (adv)
                begin
                    state_next = sbda_pkg::BK_DIGIT;
                end
            end
            sbda_pkg::BK_DIGIT:
            begin
                if (adv && idx_reg == '0)
                begin
                    state_next = sbda_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sbda_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop_ready     = 1'b0;
        emit          = 1'b0;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        unique case (state_reg)
            sbda_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                rem_next  = pop_item.mag;
                idx_next  = pop_item.top_idx;
            end
            sbda_pkg::BK_SIGN:
            begin
                if (adv)
                begin
                    emit          = 1'b1;
                    out_char_next = sbda_pkg::CHAR_MINUS;
                    out_last_next = 1'b0;
                end
            end
            sbda_pkg::BK_DIGIT:
            begin
                if (adv)
                begin
                    emit          = 1'b1;
                    out_char_next = sbda_pkg::CHAR_ZERO + 6'(digit);
                    out_last_next = (idx_reg == '0);
                    rem_next      = rem_reg - sub[sbda_pkg::VALUE_WIDTH-1:0];
                    idx_next      = idx_reg - sbda_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
        out_valid_next = emit ? 1'b1 : (text.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbda_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.text_char = out_char_reg;
    assign text.last_char = out_last_reg;

endmodule

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// Channel   Dir  Handshake        Payload
// number    in   valid / ready    value      signed two's complement, VALUE_WIDTH bits
// text      out  valid / ready    text_char  6-bit ASCII ('-' or '0'..'9')
//                                 last_char  set on the final character of a number
//
// Timing: the digit sequencer sends one character per cycle while text.ready is high,
// and passes through its idle state between numbers. After the accepting edge, the first
// character passes the queue write, the sequencer load and the output register.
// Reset: rst_n clears all handshake state at once; no clearing pass.
// Stalls: input stage and a two-deep queue let the front keep taking numbers while
// the output is held; text_char/last_char hold while text.ready is low.
module signed_binary_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    sbda_value_if.sink  number,
    sbda_char_if.source text
);

    // Front -> queue request
    logic               push_valid;
    logic               push_ready;
    sbda_pkg::bd_item_t push_item;

    // Queue -> back request
    logic               pop_valid;
    logic               pop_ready;
    sbda_pkg::bd_item_t pop_item;

    // Takes the number, forms its magnitude and finds the leading digit position.
    sbda_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .number     (number),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decouples classification from character output.
    sbda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Emits the sign of a negative number, then one digit per cycle while text.ready is high,
    // from the most significant down, subtracting the chosen multiple of the current power of ten.
    sbda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .text      (text)
    );

endmodule
